// File: design/cpm_pkg.sv
// ---------------------------------------------------------------------------
// cpm_pkg
// shared constants, codes and controller/datapath command types
// ---------------------------------------------------------------------------
package cpm_pkg;

	localparam int NUM_SLOTS  = 1024;
	localparam int NUM_FRAMES = 256;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int CNT_W      = 11;
	localparam int ENTRY_W    = 11;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FRAME = 2'd1;
	localparam logic [1:0] ST_NO_SLOT  = 2'd2;

	// access codes stored in a slot entry
	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_RD   = 2'd1;
	localparam logic [1:0] ACC_RW   = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic clr;         // clearing pass step after reset
		logic load;        // latch request fields, clear scan state
		logic fscan;       // frame scan step
		logic hscan;       // hint check step
		logic sscan;       // slot scan step
		logic scan_init;   // clear run counter, set scan index to zero or hint
		logic sel_hint;    // take hint as scan start or slot base
		logic wr;          // write step
	} cpm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cend;            // last entry of the clearing pass
		logic zero_count;
		logic too_big_frame;
		logic too_big_slot;
		logic hint_ok_start;   // hint valid and run inside table
		logic fdone;           // frame run found this step
		logic fend;            // last frame examined
		logic hfail;           // hint slot occupied
		logic hend;            // last hint slot examined
		logic sdone;
		logic send;
		logic wend;            // last write
		logic rd_valid;        // slot read data available
	} cpm_sts_t;

endpackage

// File: design/cpm_ram.sv
// ---------------------------------------------------------------------------
// cpm_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module cpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: design/cpm_datapath.sv
// ---------------------------------------------------------------------------
// cpm_datapath
// frame and slot table memories, clearing pass, scan counters and writes
// ---------------------------------------------------------------------------
module cpm_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cpm_pkg::cpm_cmd_t                cmd,
	output cpm_pkg::cpm_sts_t                sts,
	input  logic [cpm_pkg::CNT_W-1:0]        page_count,
	input  logic                             hint_valid,
	input  logic [cpm_pkg::SLOT_W-1:0]       hint_slot,
	input  logic [1:0]                       access_bits,
	output logic [cpm_pkg::SLOT_W-1:0]       slot_base_q,
	output logic [cpm_pkg::FRAME_W-1:0]      frame_base_q
);
	localparam int SW = cpm_pkg::SLOT_W;
	localparam int FW = cpm_pkg::FRAME_W;
	localparam int CW = cpm_pkg::CNT_W;

	logic [CW-1:0]   count_q;
	logic            hv_q;
	logic [SW-1:0]   hint_q;
	logic [1:0]      acc_q;
	logic [1:0]      code;
	logic [CW-1:0]   fidx_q;     // frame scan index (address issued)
	logic            frd_pend_q;
	logic [FW-1:0]   frd_addr_q;
	logic [CW-1:0]   sidx_q;     // slot scan index (address issued)
	logic [CW-1:0]   run_q;
	logic [CW-1:0]   widx_q;
	logic            rd_pend_q;
	logic [SW-1:0]   rd_addr_q;
	logic [SW-1:0]   clr_idx_q;
	logic [SW-1:0]   ram_addr;
	logic [cpm_pkg::ENTRY_W-1:0] ram_wdata;
	logic [cpm_pkg::ENTRY_W-1:0] ram_rdata;
	logic            ram_we;
	logic [FW-1:0]   fram_addr;
	logic [0:0]      fram_wdata;
	logic [0:0]      fram_rdata;
	logic            fram_we;
	logic            frame_used;
	logic            slot_busy;
	logic [CW-1:0]   run_nxt;
	logic [CW-1:0]   frun_nxt;
	logic [FW-1:0]   cur_frame;
	logic [SW-1:0]   cur_slot;
	logic [CW:0]     hint_end;

	function automatic logic [1:0] access_bits_code(input logic [1:0] a);
		logic [1:0] r;
		r = a[1] ? cpm_pkg::ACC_RW : (a[0] ? cpm_pkg::ACC_RD : cpm_pkg::ACC_NONE);
		return r;
	endfunction

	assign code = access_bits_code(acc_q);

	assign cur_frame = frame_base_q + widx_q[FW-1:0];
	assign cur_slot  = slot_base_q + widx_q[SW-1:0];
	assign hint_end  = {1'b0, CW'(hint_q)} + {1'b0, count_q};

	// slot memory address: writes, else clearing pass, else scan address
	assign ram_we    = (cmd.wr && (code != cpm_pkg::ACC_NONE)) || cmd.clr;
	assign ram_wdata = cmd.clr ? '0 : {1'b1, code, cur_frame[7:0]};
	assign ram_addr  = cmd.wr ? cur_slot : (cmd.clr ? clr_idx_q : sidx_q[SW-1:0]);

	cpm_ram #(.WIDTH(cpm_pkg::ENTRY_W), .DEPTH(cpm_pkg::NUM_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// frame flag memory: mark used on write, clear during the pass
	assign fram_we    = cmd.wr || cmd.clr;
	assign fram_wdata = {cmd.wr};
	assign fram_addr  = cmd.wr ? cur_frame : (cmd.clr ? clr_idx_q[FW-1:0] : fidx_q[FW-1:0]);

	cpm_ram #(.WIDTH(1), .DEPTH(cpm_pkg::NUM_FRAMES)) u_frame_ram (
		.clk   (clk),
		.we    (fram_we),
		.addr  (fram_addr),
		.wdata (fram_wdata),
		.rdata (fram_rdata)
	);

	// run counters on returned read data
	assign frame_used = fram_rdata[0];
	assign frun_nxt   = frame_used ? '0 : run_q + 1'b1;
	assign slot_busy  = (ram_rdata != '0);
	assign run_nxt    = slot_busy ? '0 : run_q + 1'b1;

	// status towards controller
	always_comb begin
		sts.cend          = (clr_idx_q == SW'(cpm_pkg::NUM_SLOTS - 1));
		sts.zero_count    = (count_q == '0);
		sts.too_big_frame = (count_q > CW'(cpm_pkg::NUM_FRAMES));
		sts.too_big_slot  = (count_q > CW'(cpm_pkg::NUM_SLOTS));
		sts.hint_ok_start = hv_q && (hint_end <= (CW+1)'(cpm_pkg::NUM_SLOTS));
		sts.fdone = frd_pend_q && (frun_nxt == count_q);
		sts.fend  = frd_pend_q && (frd_addr_q == FW'(cpm_pkg::NUM_FRAMES - 1));
		sts.rd_valid = rd_pend_q;
		sts.hfail = rd_pend_q && slot_busy;
		sts.hend  = rd_pend_q && (CW'(rd_addr_q) + 1'b1 == hint_end[CW-1:0]);
		sts.sdone = rd_pend_q && !slot_busy && (run_nxt == count_q);
		sts.send  = rd_pend_q && (rd_addr_q == SW'(cpm_pkg::NUM_SLOTS - 1));
		sts.wend  = (widx_q + 1'b1 == count_q);
	end

	// request fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			count_q <= page_count;
			hv_q    <= hint_valid;
			hint_q  <= hint_slot;
			acc_q   <= access_bits;
		end
	end

	// scan counters and bases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q       <= '0;
			frd_pend_q   <= 1'b0;
			frd_addr_q   <= '0;
			sidx_q       <= '0;
			run_q        <= '0;
			widx_q       <= '0;
			rd_pend_q    <= 1'b0;
			rd_addr_q    <= '0;
			clr_idx_q    <= '0;
			slot_base_q  <= '0;
			frame_base_q <= '0;
		end else begin
			// read pipeline: issue next read, consume previous
			frd_pend_q <= cmd.fscan;
			rd_pend_q  <= cmd.hscan || cmd.sscan;
			if (cmd.fscan) begin
				frd_addr_q <= fidx_q[FW-1:0];
			end
			if (cmd.hscan || cmd.sscan) begin
				rd_addr_q <= sidx_q[SW-1:0];
			end
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end

			if (cmd.load) begin
				fidx_q <= '0;
			end else if (cmd.fscan) begin
				fidx_q <= fidx_q + 1'b1;
			end

			if (cmd.load || cmd.scan_init) begin
				run_q <= '0;
			end else if (cmd.fscan && frd_pend_q) begin
				run_q <= frun_nxt;
			end else if ((cmd.hscan || cmd.sscan) && rd_pend_q) begin
				run_q <= run_nxt;
			end

			if (cmd.scan_init) begin
				sidx_q <= cmd.sel_hint ? CW'(hint_q) : '0;
			end else if (cmd.hscan || cmd.sscan) begin
				sidx_q <= sidx_q + 1'b1;
			end

			if (cmd.load) begin
				frame_base_q <= '0;
			end else if (cmd.fscan && frd_pend_q) begin
				frame_base_q <= FW'(CW'(frd_addr_q) + 1'b1 - count_q);
			end

			if (cmd.load) begin
				slot_base_q <= '0;
			end else if (cmd.sel_hint && !cmd.scan_init) begin
				slot_base_q <= hint_q;
			end else if (cmd.sscan && rd_pend_q) begin
				slot_base_q <= SW'(CW'(rd_addr_q) + 1'b1 - count_q);
			end

			if (cmd.load) begin
				widx_q <= '0;
			end else if (cmd.wr) begin
				widx_q <= widx_q + 1'b1;
			end
		end
	end
endmodule

// File: design/cpm_ctrl.sv
// ---------------------------------------------------------------------------
// cpm_ctrl
// request sequencer: frame scan, hint check, slot scan, write, respond
// ---------------------------------------------------------------------------
module cpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output cpm_pkg::cpm_cmd_t cmd,
	input  cpm_pkg::cpm_sts_t sts
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_FSCAN = 3'd2;
	localparam logic [2:0] S_HSCAN = 3'd3;
	localparam logic [2:0] S_SSCAN = 3'd4;
	localparam logic [2:0] S_WRITE = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;
	localparam logic [2:0] S_CLEAR = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [1:0] status_q;
	logic [1:0] status_nxt;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign status    = status_q;

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		status_nxt = status_q;
		cmd        = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.cend) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.zero_count || sts.too_big_frame) begin
					status_nxt = cpm_pkg::ST_NO_FRAME;
					state_nxt  = S_RESP;
				end else begin
					state_nxt = S_FSCAN;
				end
			end
			S_FSCAN: begin
				cmd.fscan = 1'b1;
				if (sts.fdone) begin
					cmd.scan_init = 1'b1;
					cmd.sel_hint  = sts.hint_ok_start;
					state_nxt = sts.hint_ok_start ? S_HSCAN : S_SSCAN;
				end else if (sts.fend) begin
					status_nxt = cpm_pkg::ST_NO_FRAME;
					state_nxt  = S_RESP;
				end
			end
			S_HSCAN: begin
				cmd.hscan = 1'b1;
				if (sts.hfail) begin
					cmd.hscan     = 1'b0;
					cmd.scan_init = 1'b1;
					state_nxt = S_SSCAN;
				end else if (sts.hend) begin
					cmd.hscan    = 1'b0;
					cmd.sel_hint = 1'b1;
					state_nxt    = S_WRITE;
				end
			end
			S_SSCAN: begin
				cmd.sscan = 1'b1;
				if (sts.sdone) begin
					state_nxt = S_WRITE;
				end else if (sts.send) begin
					status_nxt = cpm_pkg::ST_NO_SLOT;
					state_nxt  = S_RESP;
				end
			end
			S_WRITE: begin
				cmd.wr = 1'b1;
				if (sts.wend) begin
					status_nxt = cpm_pkg::ST_OK;
					state_nxt  = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			status_q <= cpm_pkg::ST_OK;
		end else begin
			state_q  <= state_nxt;
			status_q <= status_nxt;
		end
	end
endmodule

// File: design/contiguous_page_mapper_core.sv
// sequence: each request passes a check state, a frame scan, a hint check
// when the hint is valid and fits, a slot scan (one entry per cycle plus the
// read pipeline) and the write loop over count pages, count at most 256; a
// zero or oversize count answers from the check state with no scan
// throughput: one request at a time, the next is taken after the result beat
// reset: asynchronous; a clearing pass of both tables follows, input stalled
// ---------------------------------------------------------------------------
// contiguous_page_mapper_core
// first-fit contiguous page allocator top level
// ---------------------------------------------------------------------------
module contiguous_page_mapper_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cpm_pkg::CNT_W-1:0]  page_count,
	input  logic                       hint_valid,
	input  logic [cpm_pkg::SLOT_W-1:0] hint_slot,
	input  logic [1:0]                 access_bits,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [cpm_pkg::SLOT_W-1:0] base_slot,
	output logic [cpm_pkg::FRAME_W-1:0] base_frame
);
	cpm_pkg::cpm_cmd_t cmd;
	cpm_pkg::cpm_sts_t sts;
	logic [cpm_pkg::SLOT_W-1:0]  slot_base;
	logic [cpm_pkg::FRAME_W-1:0] frame_base;

	cpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.sts       (sts)
	);

	cpm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.page_count   (page_count),
		.hint_valid   (hint_valid),
		.hint_slot    (hint_slot),
		.access_bits  (access_bits),
		.slot_base_q  (slot_base),
		.frame_base_q (frame_base)
	);

	// bases read as zero on failure
	assign base_slot  = (status == cpm_pkg::ST_OK) ? slot_base : '0;
	assign base_frame = (status == cpm_pkg::ST_OK) ? frame_base : '0;
endmodule

// File: design/cpm_checker.sv
// ---------------------------------------------------------------------------
// cpm_checker
// port level checks on the mapper handshakes and results
// ---------------------------------------------------------------------------
module cpm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [9:0] base_slot,
	input logic [7:0] base_frame
);
	// a result beat never coincides with taking a request
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

	// status is a defined code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("bad status code");

	// failures report zero bases
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != cpm_pkg::ST_OK) |-> (base_slot == '0 && base_frame == '0))
		else $error("nonzero base on failure");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)))
		else $error("result changed under stall");
endmodule

bind contiguous_page_mapper_core cpm_checker u_cpm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.base_slot  (base_slot),
	.base_frame (base_frame)
);

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for contiguous_page_mapper_core: requests are queued up
// front, driven with random gaps, and every result beat is checked against a
// predictor of the frame and slot tables kept inside the bench
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT    = 9;
	localparam int WDOG_LIMIT  = 20000;
	localparam int TAIL_CYCLES = 100;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		int         count;
		bit         hint_on;
		int         hint_at;
		logic [1:0] acc;
		bit         drain_first;
	} request_t;

	typedef struct {
		logic [1:0]                  status;
		logic [cpm_pkg::SLOT_W-1:0]  slot;
		logic [cpm_pkg::FRAME_W-1:0] frame;
	} mapping_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [cpm_pkg::CNT_W-1:0] page_count = '0;
	logic hint_valid = 1'b0;
	logic [cpm_pkg::SLOT_W-1:0] hint_slot = '0;
	logic [1:0] access_bits = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [cpm_pkg::SLOT_W-1:0] base_slot;
	logic [cpm_pkg::FRAME_W-1:0] base_frame;

	// bench copy of the tables
	logic [cpm_pkg::ENTRY_W-1:0] slot_map [cpm_pkg::NUM_SLOTS];
	bit frame_busy [cpm_pkg::NUM_FRAMES];

	request_t pending_requests[$];
	mapping_t expected_mappings[$];
	request_t on_bus;
	int requests_sent = 0;
	int mappings_seen = 0;
	int mismatches = 0;
	int ok_seen = 0, no_frame_seen = 0, no_slot_seen = 0;
	int quiet_cycles;
	bit quiet;

	contiguous_page_mapper_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.page_count(page_count), .hint_valid(hint_valid),
		.hint_slot(hint_slot), .access_bits(access_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .base_slot(base_slot), .base_frame(base_frame)
	);

	always #5 clk = ~clk;

	// first-fit allocation on the bench tables
	function automatic mapping_t allocate_run(int n, bit hint_on, int hint_at,
			logic [1:0] acc);
		mapping_t r;
		int f, s, run, i;
		bit hint_fits;
		logic [1:0] code;
		r.status = cpm_pkg::ST_NO_FRAME;
		r.slot = '0;
		r.frame = '0;
		f = -1;
		s = -1;
		run = 0;
		// lowest run of free frames
		if (n > 0 && n <= cpm_pkg::NUM_FRAMES) begin
			for (i = 0; i < cpm_pkg::NUM_FRAMES && f < 0; i++) begin
				run = frame_busy[i] ? 0 : run + 1;
				if (run == n) f = i + 1 - n;
			end
		end
		if (f < 0) return r;
		// hinted run if wholly empty and inside the table
		hint_fits = hint_on && n <= cpm_pkg::NUM_SLOTS && hint_at <= cpm_pkg::NUM_SLOTS - n;
		for (i = 0; hint_fits && i < n; i++)
			if (slot_map[hint_at + i] != '0) hint_fits = 1'b0;
		if (hint_fits) begin
			s = hint_at;
		end else if (n <= cpm_pkg::NUM_SLOTS) begin
			run = 0;
			for (i = 0; i < cpm_pkg::NUM_SLOTS && s < 0; i++) begin
				run = (slot_map[i] != '0) ? 0 : run + 1;
				if (run == n) s = i + 1 - n;
			end
		end
		if (s < 0) begin
			r.status = cpm_pkg::ST_NO_SLOT;
			return r;
		end
		// read-write wins over read
		code = acc[1] ? cpm_pkg::ACC_RW : (acc[0] ? cpm_pkg::ACC_RD : cpm_pkg::ACC_NONE);
		for (i = 0; i < n; i++) begin
			if (code != cpm_pkg::ACC_NONE)
				slot_map[s + i] = {1'b1, code, 8'((f + i) & 8'hFF)};
			frame_busy[f + i] = 1'b1;
		end
		r.status = cpm_pkg::ST_OK;
		r.slot = cpm_pkg::SLOT_W'(s);
		r.frame = cpm_pkg::FRAME_W'(f);
		return r;
	endfunction

	function automatic request_t make_request(int n, bit hon, int hat,
			logic [1:0] acc);
		request_t q;
		q.count = n;
		q.hint_on = hon;
		q.hint_at = hat;
		q.acc = acc;
		q.drain_first = 1'b0;
		return q;
	endfunction

	// no idling in a stretch in the middle of the run
	always_comb quiet = requests_sent >= 60 && requests_sent < 120;

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				expected_mappings.push_back(allocate_run(on_bus.count, on_bus.hint_on,
					on_bus.hint_at, on_bus.acc));
				requests_sent++;
			end
			if (pending_requests.size() > 0
					&& !(pending_requests[0].drain_first && expected_mappings.size() > 0)
					&& (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				on_bus = pending_requests.pop_front();
				page_count <= cpm_pkg::CNT_W'(on_bus.count);
				hint_valid <= on_bus.hint_on;
				hint_slot <= cpm_pkg::SLOT_W'(on_bus.hint_at);
				access_bits <= on_bus.acc;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		mapping_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				mappings_seen++;
				if (expected_mappings.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result beat: status %0d slot %0d frame %0d",
							status, base_slot, base_frame);
				end else begin
					want = expected_mappings.pop_front();
					case (want.status)
						cpm_pkg::ST_OK:       ok_seen++;
						cpm_pkg::ST_NO_FRAME: no_frame_seen++;
						default:              no_slot_seen++;
					endcase
					if (status !== want.status || base_slot !== want.slot
							|| base_frame !== want.frame) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
								mappings_seen, want.status, want.slot, want.frame,
								status, base_slot, base_frame);
					end
				end
			end
			out_stall <= !quiet && $urandom_range(0, 99) < IDLE_PCT;
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("watchdog expired");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int k, roll;
		request_t q;
		quiet_cycles = 0;
		for (k = 0; k < cpm_pkg::NUM_SLOTS; k++) slot_map[k] = '0;
		for (k = 0; k < cpm_pkg::NUM_FRAMES; k++) frame_busy[k] = 1'b0;

		// directed: zero count, oversize, hint at the end, occupied hint,
		// no-access pages, every access code
		pending_requests.push_back(make_request(0, 1'b1, 5, 2'd1));
		pending_requests.push_back(make_request(1024, 1'b1, 0, 2'd3));
		pending_requests.push_back(make_request(257, 1'b0, 0, 2'd2));
		pending_requests.push_back(make_request(256 + 1, 1'b1, 1023, 2'd0));
		pending_requests.push_back(make_request(1, 1'b1, 1023, 2'd3));
		pending_requests.push_back(make_request(2, 1'b1, 1023, 2'd1));
		pending_requests.push_back(make_request(1, 1'b1, 0, 2'd2));
		pending_requests.push_back(make_request(3, 1'b0, 1023, 2'd0));
		pending_requests.push_back(make_request(1, 1'b1, 3, 2'd2));
		pending_requests.push_back(make_request(2, 1'b1, 1022, 2'd1));
		pending_requests.push_back(make_request(16, 1'b1, 'h2AA, 2'd3));
		pending_requests.push_back(make_request(1, 1'b1, 'h155, 2'd1));
		pending_requests.push_back(make_request(1024, 1'b0, 0, 2'd0));
		pending_requests.push_back(make_request(2047, 1'b1, 'h3FF, 2'd3));

		// random: mostly single pages hinted onto a stride of five slots so
		// that slots fragment, then longer runs that find no slot run
		for (k = 0; k < 290; k++) begin
			roll = $urandom_range(0, 99);
			if (k >= 250)
				q = make_request($urandom_range(5, 12), $urandom_range(0, 1),
					$urandom_range(0, 1023), 2'($urandom_range(0, 3)));
			else if (roll < 60)
				q = make_request(1, 1'b1, 5 * $urandom_range(0, 204),
					2'($urandom_range(1, 3)));
			else if (roll < 78)
				q = make_request($urandom_range(1, 4), $urandom_range(0, 1),
					$urandom_range(0, 1023), 2'($urandom_range(0, 3)));
			else if (roll < 88)
				q = make_request($urandom_range(5, 12), $urandom_range(0, 1),
					$urandom_range(0, 1023), 2'($urandom_range(0, 3)));
			else if (roll < 95)
				q = make_request($urandom_range(257, 2047), $urandom_range(0, 1),
					$urandom_range(0, 1023), 2'($urandom_range(0, 3)));
			else
				q = make_request(0, $urandom_range(0, 1), $urandom_range(0, 1023),
					2'($urandom_range(0, 3)));
			// pause the sender once until the block has drained
			q.drain_first = (k == 150);
			pending_requests.push_back(q);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() > 0 || in_valid || expected_mappings.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results: %0d mapped, %0d out of frames, %0d out of slots",
			requests_sent, mappings_seen, ok_seen, no_frame_seen, no_slot_seen);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
